>>> hdl/pfc_pkg.sv
package pfc_pkg;

    // Geometry of the key square
    localparam int SIDE  = 5;
    localparam int CELLS = SIDE * SIDE;

    typedef logic [4:0]       code_t;    // letter code, A=0 .. Z=25
    typedef logic [2:0]       idx_t;     // row or column index
    typedef code_t [CELLS-1:0] square_t; // cell r*SIDE+c at entry r*SIDE+c

    typedef struct packed {
        code_t a;
        code_t b;
    } pair_t;

    // Letter codes and ASCII
    localparam code_t      CODE_X  = 5'd23;
    localparam code_t      CODE_I  = 5'd8;
    localparam code_t      CODE_J  = 5'd9;
    localparam logic [7:0] ASCII_A = 8'h41;
    localparam logic [7:0] ASCII_Z = 8'h5A;

    // Register indexes
    localparam logic [1:0] REG_SQUARE_LOW = 2'd0;
    localparam logic [1:0] REG_SQUARE_MID = 2'd1;
    localparam logic [1:0] REG_SQUARE_END = 2'd2;
    localparam logic [1:0] REG_DIRECTION  = 2'd3;

    // Reset square: keyword WHEATSON
    localparam logic [59:0] RST_SQUARE_LOW = 60'd183593615404044534;
    localparam logic [59:0] RST_SQUARE_MID = 60'd891348290170628358;
    localparam code_t       RST_SQUARE_END = 5'd25;

    // Step one row or column forward, or backward, with wrap
    function automatic idx_t shift_index(idx_t v, logic back);
        idx_t r;
        if (back) begin
            r = (v == 3'd0) ? idx_t'(SIDE - 1) : idx_t'(v - 3'd1);
        end else begin
            r = (v == idx_t'(SIDE - 1)) ? 3'd0 : idx_t'(v + 3'd1);
        end
        return r;
    endfunction

endpackage

>>> hdl/pfc_pair_cipher.sv
module pfc_pair_cipher (
    input  pfc_pkg::square_t sq,
    input  logic             back,
    input  pfc_pkg::pair_t   pair_in,
    output pfc_pkg::pair_t   pair_out
);

    logic          found_a, found_b;
    pfc_pkg::idx_t row_a, col_a, row_b, col_b;

    function automatic pfc_pkg::code_t cell_at(pfc_pkg::square_t s, pfc_pkg::idx_t r,
                                               pfc_pkg::idx_t c);
        logic [4:0] i;
        i = 5'(5'(r) * 5'(pfc_pkg::SIDE)) + 5'(c);
        return s[i];
    endfunction

    // Locate both letters; lowest cell wins, so scan from the top down
    always_comb begin
        found_a = 1'b0;
        found_b = 1'b0;
        row_a   = '0;
        col_a   = '0;
        row_b   = '0;
        col_b   = '0;
        for (int r = pfc_pkg::SIDE - 1; r >= 0; r--) begin
            for (int c = pfc_pkg::SIDE - 1; c >= 0; c--) begin
                if (sq[5'(r * pfc_pkg::SIDE + c)] == pair_in.a) begin
                    found_a = 1'b1;
                    row_a   = pfc_pkg::idx_t'(r);
                    col_a   = pfc_pkg::idx_t'(c);
                end
                if (sq[5'(r * pfc_pkg::SIDE + c)] == pair_in.b) begin
                    found_b = 1'b1;
                    row_b   = pfc_pkg::idx_t'(r);
                    col_b   = pfc_pkg::idx_t'(c);
                end
            end
        end
    end

    // Apply rectangle, row or column rule
    always_comb begin
        pair_out = pair_in;
        if (found_a && found_b && !(row_a == row_b && col_a == col_b)) begin
            priority if (row_a != row_b && col_a != col_b) begin
                pair_out.a = cell_at(sq, row_a, col_b);
                pair_out.b = cell_at(sq, row_b, col_a);
            end else if (row_a == row_b) begin
                pair_out.a = cell_at(sq, row_a, pfc_pkg::shift_index(col_a, back));
                pair_out.b = cell_at(sq, row_b, pfc_pkg::shift_index(col_b, back));
            end else begin
                pair_out.a = cell_at(sq, pfc_pkg::shift_index(row_a, back), col_a);
                pair_out.b = cell_at(sq, pfc_pkg::shift_index(row_b, back), col_b);
            end
        end
    end

endmodule

>>> hdl/playfair_digraph_cipher.sv
// Playfair cipher on a byte stream. Each input word is one ASCII byte
// (s_tlast marks the end of a message); letters are paired and each pair
// leaves as two enciphered ASCII letters on the m_ side, m_tlast set on the
// last letter caused by an input word. Input is taken into a front register
// whenever that register is free, so words that close no pair stream at one
// per cycle. Each pair then passes the single cipher unit into the output
// register, which hands out its two letters in turn; a word that closes
// pairs holds the input until its last pair is loaded into the output
// register. The key square and direction are to be written through
// cfg_we/cfg_addr/cfg_wdata only while the stream is idle; the block
// itself does not enforce this.
module playfair_digraph_cipher (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [59:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // end_of_message
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] cipher_char
    output logic        m_tlast    // last_of_run
);

    logic [59:0]     sq_low_reg, sq_mid_reg;
    pfc_pkg::code_t  sq_end_reg;
    logic            dir_reg;
    pfc_pkg::square_t square;

    pfc_pkg::code_t  pend_reg, pend_next;
    logic            pend_valid_reg, pend_valid_next;

    logic            a_valid_reg, a_two_reg, a_sel_reg;
    pfc_pkg::pair_t  a_pair0_reg, a_pair1_reg;

    logic            b_valid_reg, b_pos_reg, b_last_reg;
    logic [7:0]      b_char0_reg, b_char1_reg;

    logic            accept_in, b_free, b_load, a_last_pair;
    logic [1:0]      new_npairs;
    pfc_pkg::pair_t  new_pair0, new_pair1, cur_pair, enc_pair;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_low_reg <= pfc_pkg::RST_SQUARE_LOW;
            sq_mid_reg <= pfc_pkg::RST_SQUARE_MID;
            sq_end_reg <= pfc_pkg::RST_SQUARE_END;
            dir_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pfc_pkg::REG_SQUARE_LOW: sq_low_reg <= cfg_wdata;
                pfc_pkg::REG_SQUARE_MID: sq_mid_reg <= cfg_wdata;
                pfc_pkg::REG_SQUARE_END: sq_end_reg <= cfg_wdata[4:0];
                pfc_pkg::REG_DIRECTION:  dir_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Unpack the square into cells
    always_comb begin
        for (int i = 0; i < 12; i++) begin
            square[5'(i)]      = sq_low_reg[6'(5*i) +: 5];
            square[5'(i + 12)] = sq_mid_reg[6'(5*i) +: 5];
        end
        square[pfc_pkg::CELLS-1] = sq_end_reg;
    end

    // Handshake glue
    assign accept_in   = s_tvalid && s_tready;
    assign b_free      = !b_valid_reg || (b_pos_reg && m_tready);
    assign b_load      = a_valid_reg && b_free;
    assign a_last_pair = a_sel_reg || !a_two_reg;
    assign s_tready    = !a_valid_reg || (b_load && a_last_pair);

    // Pair up the incoming letter with the pending one
    always_comb begin
        logic           is_letter;
        pfc_pkg::code_t letter;
        is_letter       = (s_tdata >= pfc_pkg::ASCII_A) && (s_tdata <= pfc_pkg::ASCII_Z);
        letter          = 5'(s_tdata - pfc_pkg::ASCII_A);
        if (letter == pfc_pkg::CODE_J) begin
            letter = pfc_pkg::CODE_I;
        end
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        new_npairs      = 2'd0;
        new_pair0       = '{a: letter, b: pfc_pkg::CODE_X};
        new_pair1       = '{a: letter, b: pfc_pkg::CODE_X};
        if (is_letter) begin
            priority if (!pend_valid_reg) begin
                pend_next       = letter;
                pend_valid_next = 1'b1;
            end else if (pend_reg == letter) begin
                new_npairs = 2'd1;
            end else begin
                new_pair0       = '{a: pend_reg, b: letter};
                new_npairs      = 2'd1;
                pend_valid_next = 1'b0;
            end
        end
        // Flush a lone letter with X padding
        if (s_tlast && pend_valid_next) begin
            if (new_npairs == 2'd0) begin
                new_pair0 = '{a: pend_next, b: pfc_pkg::CODE_X};
            end else begin
                new_pair1 = '{a: pend_next, b: pfc_pkg::CODE_X};
            end
            new_npairs      = 2'(new_npairs + 2'd1);
            pend_valid_next = 1'b0;
        end
    end

    // Pending letter and front register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            a_valid_reg    <= 1'b0;
            a_sel_reg      <= 1'b0;
        end else begin
            if (accept_in) begin
                pend_reg       <= pend_next;
                pend_valid_reg <= pend_valid_next;
                a_valid_reg    <= (new_npairs != 2'd0);
                a_sel_reg      <= 1'b0;
            end else if (b_load) begin
                if (a_last_pair) begin
                    a_valid_reg <= 1'b0;
                end else begin
                    a_sel_reg <= 1'b1;
                end
            end
        end
    end

    // Front register payload
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            a_two_reg   <= (new_npairs == 2'd2);
            a_pair0_reg <= new_pair0;
            a_pair1_reg <= new_pair1;
        end
    end

    // Encipher the current pair
    assign cur_pair = a_sel_reg ? a_pair1_reg : a_pair0_reg;

    pfc_pair_cipher u_cipher (
        .sq       (square),
        .back     (dir_reg),
        .pair_in  (cur_pair),
        .pair_out (enc_pair)
    );

    // Output register: two letters handed out in turn
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            b_pos_reg   <= 1'b0;
        end else if (b_load) begin
            b_valid_reg <= 1'b1;
            b_pos_reg   <= 1'b0;
        end else if (b_valid_reg && m_tready) begin
            if (b_pos_reg) begin
                b_valid_reg <= 1'b0;
                b_pos_reg   <= 1'b0;
            end else begin
                b_pos_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_char0_reg <= pfc_pkg::ASCII_A + {3'b000, enc_pair.a};
            b_char1_reg <= pfc_pkg::ASCII_A + {3'b000, enc_pair.b};
            b_last_reg  <= a_last_pair;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = b_pos_reg ? b_char1_reg : b_char0_reg;
    assign m_tlast  = b_pos_reg && b_last_reg;

`ifndef SYNTHESIS
    // Second pair is selected only when two pairs were queued
    a_sel_two: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && a_sel_reg |-> a_two_reg)
        else $error("second pair selected for a single-pair word");

    // Input is taken while the front register is busy only as it drains
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_in && a_valid_reg |-> b_load && a_last_pair)
        else $error("front register overwritten before it drained");

    // Second letter position only on a loaded output register
    b_pos_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        b_pos_reg |-> b_valid_reg)
        else $error("output letter position set without a pair");

    // A loaded pair always shows its first letter next
    b_first: assert property (@(posedge aclk) disable iff (!aresetn)
        b_load |=> b_valid_reg && !b_pos_reg)
        else $error("output register did not start on first letter");
`endif

endmodule

>>> sim/tb_top.sv
module tb_top;

    // One input word and one expected output letter
    typedef struct {
        logic [7:0] chr;
        logic       eom;
        logic       hold_for_drain;
    } word_t;

    typedef struct {
        logic [7:0] chr;
        logic       last;
    } letter_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = pfc_pkg::REG_SQUARE_LOW;
    logic [59:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    word_t   send_q[$];     // words waiting for the driver
    letter_t cipher_q[$];   // enciphered letters still owed by the block

    // Own copy of the key square, direction and pairing state
    pfc_pkg::code_t key_cells [pfc_pkg::CELLS];
    logic           decrypt_mode;
    pfc_pkg::code_t open_letter;
    logic           open_valid;

    int         mismatches      = 0;
    int         words_taken     = 0;
    int         burst_left      = 0;
    int         gap_left        = 0;
    int         hold_left       = 0;
    logic       long_hold_done  = 1'b0;
    int         rx_cycles       = 0;
    logic [7:0] prev_letter     = pfc_pkg::ASCII_A;

    playfair_digraph_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Lowest cell holding a letter, -1 when absent
    function automatic int locate(pfc_pkg::code_t l);
        int pos;
        pos = -1;
        for (int i = pfc_pkg::CELLS - 1; i >= 0; i--) begin
            if (key_cells[5'(i)] == l) pos = i;
        end
        return pos;
    endfunction

    function automatic int step_rc(int v);
        if (decrypt_mode) begin
            return (v == 0) ? pfc_pkg::SIDE - 1 : v - 1;
        end
        return (v == pfc_pkg::SIDE - 1) ? 0 : v + 1;
    endfunction

    // Encipher one digraph; returns both ASCII letters, first in the upper byte
    function automatic logic [15:0] encipher_pair(pfc_pkg::code_t a, pfc_pkg::code_t b);
        int             pa, pb, ra, ka, rb, kb;
        pfc_pkg::code_t ca, cb;
        pa = locate(a);
        pb = locate(b);
        ca = a;
        cb = b;
        if (pa >= 0 && pb >= 0 && pa != pb) begin
            ra = pa / pfc_pkg::SIDE;
            ka = pa % pfc_pkg::SIDE;
            rb = pb / pfc_pkg::SIDE;
            kb = pb % pfc_pkg::SIDE;
            if (ra != rb && ka != kb) begin
                ca = key_cells[5'(ra * pfc_pkg::SIDE + kb)];
                cb = key_cells[5'(rb * pfc_pkg::SIDE + ka)];
            end else if (ra == rb) begin
                ca = key_cells[5'(ra * pfc_pkg::SIDE + step_rc(ka))];
                cb = key_cells[5'(rb * pfc_pkg::SIDE + step_rc(kb))];
            end else begin
                ca = key_cells[5'(step_rc(ra) * pfc_pkg::SIDE + ka)];
                cb = key_cells[5'(step_rc(rb) * pfc_pkg::SIDE + kb)];
            end
        end
        return {pfc_pkg::ASCII_A + 8'(ca), pfc_pkg::ASCII_A + 8'(cb)};
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [59:0] val);
        case (idx)
            pfc_pkg::REG_SQUARE_LOW: begin
                for (int i = 0; i < 12; i++) key_cells[5'(i)] = val[6'(5 * i) +: 5];
            end
            pfc_pkg::REG_SQUARE_MID: begin
                for (int i = 0; i < 12; i++) key_cells[5'(12 + i)] = val[6'(5 * i) +: 5];
            end
            pfc_pkg::REG_SQUARE_END: key_cells[24] = val[4:0];
            pfc_pkg::REG_DIRECTION:  decrypt_mode = val[0];
            default: ;
        endcase
    endfunction

    // Work out the letters one accepted word causes and queue them
    task automatic predict_word(logic [7:0] chr, logic eom);
        logic [7:0]     got [4];
        int             n;
        pfc_pkg::code_t l;
        logic [15:0]    pr;
        letter_t        e;
        n = 0;
        if (chr >= pfc_pkg::ASCII_A && chr <= pfc_pkg::ASCII_Z) begin
            l = pfc_pkg::code_t'(chr - pfc_pkg::ASCII_A);
            if (l == pfc_pkg::CODE_J) l = pfc_pkg::CODE_I;
            if (!open_valid) begin
                open_letter = l;
                open_valid  = 1'b1;
            end else if (open_letter == l) begin
                // doubled letter: close with X, second copy stays open
                pr = encipher_pair(l, pfc_pkg::CODE_X);
                got[2'(n)] = pr[15:8];
                got[2'(n + 1)] = pr[7:0];
                n += 2;
            end else begin
                pr = encipher_pair(open_letter, l);
                got[2'(n)] = pr[15:8];
                got[2'(n + 1)] = pr[7:0];
                n += 2;
                open_valid = 1'b0;
            end
        end
        // flush a lone letter at end of message
        if (eom && open_valid) begin
            pr = encipher_pair(open_letter, pfc_pkg::CODE_X);
            got[2'(n)] = pr[15:8];
            got[2'(n + 1)] = pr[7:0];
            n += 2;
            open_valid = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            e.chr  = got[2'(i)];
            e.last = (i == n - 1);
            cipher_q = {cipher_q, e};
        end
    endtask

    task automatic queue_word(logic [7:0] c, logic eom, logic drain);
        word_t w;
        w.chr = c;
        w.eom = eom;
        w.hold_for_drain = drain;
        send_q = {send_q, w};
    endtask

    // Mostly letters with doubles, some X/J, spaces and raw bytes
    task automatic add_random(int n);
        logic [7:0] c;
        int         r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 65) c = pfc_pkg::ASCII_A + 8'($urandom_range(0, 25));
            else if (r < 78) c = prev_letter;
            else if (r < 84) c = ($urandom_range(0, 1) != 0) ? "X" : "J";
            else if (r < 90) c = " ";
            else c = 8'($urandom_range(0, 255));
            if (c >= pfc_pkg::ASCII_A && c <= pfc_pkg::ASCII_Z) prev_letter = c;
            queue_word(c, $urandom_range(0, 9) == 0, 1'b0);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [59:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        apply_reg(idx, val);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Wait for the stream to run dry, then let the pipeline settle
    task automatic settle();
        while (send_q.size() > 0 || s_tvalid || cipher_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Driver: bursts of words with random gaps
    always @(posedge aclk) begin
        word_t w;
        logic  offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = 1'b0;
            if (s_tvalid && s_tready) begin
                predict_word(s_tdata, s_tlast);
                words_taken <= words_taken + 1;
            end
            if (s_tvalid && !s_tready) begin
                offer = 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (send_q.size() > 0 &&
                         !(send_q[0].hold_for_drain && cipher_q.size() > 0)) begin
                w = send_q.pop_front();
                s_tdata <= w.chr;
                s_tlast <= w.eom;
                offer = 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
            s_tvalid <= offer;
        end
    end

    // Receiver: alternate free and choppy stretches, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            if (!long_hold_done && words_taken >= 80) begin
                hold_left      <= 300;
                long_hold_done <= 1'b1;
                m_tready       <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (rx_cycles[6]) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Monitor: compare every output word with the oldest expected letter
    always @(posedge aclk) begin
        letter_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual chr=%h last=%b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                e = cipher_q.pop_front();
                if (m_tdata !== e.chr) begin
                    $display("%0t: cipher_char mismatch, expected %h, actual %h",
                             $time, e.chr, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last_of_run mismatch, expected %b, actual %b",
                             $time, e.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        pfc_pkg::code_t perm [25];
        pfc_pkg::code_t t;
        int             j;
        logic [59:0]    lo, mi;
        string          seq;

        apply_reg(pfc_pkg::REG_SQUARE_LOW, pfc_pkg::RST_SQUARE_LOW);
        apply_reg(pfc_pkg::REG_SQUARE_MID, pfc_pkg::RST_SQUARE_MID);
        apply_reg(pfc_pkg::REG_SQUARE_END, 60'(pfc_pkg::RST_SQUARE_END));
        apply_reg(pfc_pkg::REG_DIRECTION, '0);
        open_letter = '0;
        open_valid  = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset square, encrypt: row, column, rectangle, doubles, XX, J fold
        seq = "WEWSHNLLAXXYJI";
        for (int i = 0; i < seq.len(); i++) queue_word(seq[i], 1'b0, 1'b0);
        queue_word(" ", 1'b1, 1'b0);
        queue_word(8'h00, 1'b0, 1'b0);
        queue_word(8'hFF, 1'b0, 1'b0);
        queue_word(8'h40, 1'b0, 1'b0);
        queue_word(8'h5B, 1'b0, 1'b0);
        queue_word(8'h61, 1'b0, 1'b0);
        queue_word("A", 1'b1, 1'b0);
        queue_word("Z", 1'b0, 1'b0);
        queue_word("A", 1'b1, 1'b0);
        queue_word(" ", 1'b1, 1'b0);
        queue_word("B", 1'b0, 1'b0);
        queue_word("B", 1'b1, 1'b0);
        add_random(40);
        settle();

        // Reset square, decrypt
        write_reg(pfc_pkg::REG_SQUARE_LOW, pfc_pkg::RST_SQUARE_LOW);
        write_reg(pfc_pkg::REG_SQUARE_MID, pfc_pkg::RST_SQUARE_MID);
        write_reg(pfc_pkg::REG_SQUARE_END, 60'(pfc_pkg::RST_SQUARE_END));
        write_reg(pfc_pkg::REG_DIRECTION, 60'd1);
        add_random(40);
        settle();

        // Shuffled square of the 25 letters without J, random direction
        for (int i = 0; i < 25; i++) begin
            perm[5'(i)] = (i < 9) ? pfc_pkg::code_t'(i) : pfc_pkg::code_t'(i + 1);
        end
        for (int i = 24; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[5'(i)];
            perm[5'(i)] = perm[5'(j)];
            perm[5'(j)] = t;
        end
        for (int i = 0; i < 12; i++) begin
            lo[6'(5 * i) +: 5] = perm[5'(i)];
            mi[6'(5 * i) +: 5] = perm[5'(12 + i)];
        end
        write_reg(pfc_pkg::REG_SQUARE_LOW, lo);
        write_reg(pfc_pkg::REG_SQUARE_MID, mi);
        write_reg(pfc_pkg::REG_SQUARE_END, 60'(perm[24]));
        write_reg(pfc_pkg::REG_DIRECTION, 60'($urandom_range(0, 1)));
        add_random(20);
        queue_word("Q", 1'b0, 1'b1);
        add_random(30);
        settle();

        // Top cells all unmatched codes, random middle, decrypt
        lo = '1;
        mi = 60'({$urandom(), $urandom()});
        write_reg(pfc_pkg::REG_SQUARE_LOW, lo);
        write_reg(pfc_pkg::REG_SQUARE_MID, mi);
        write_reg(pfc_pkg::REG_SQUARE_END, 60'd0);
        write_reg(pfc_pkg::REG_DIRECTION, 60'd1);
        add_random(40);
        settle();

        // Square of repeated A with Z in the last cell, encrypt
        write_reg(pfc_pkg::REG_SQUARE_LOW, '0);
        write_reg(pfc_pkg::REG_SQUARE_MID, '0);
        write_reg(pfc_pkg::REG_SQUARE_END, 60'd25);
        write_reg(pfc_pkg::REG_DIRECTION, 60'd0);
        add_random(30);
        settle();

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
